>>> sv/rgb_to_hsv_pixel_assert.svh
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel assertion macros
// shared concurrent assertion forms for the pixel converter
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define RGBHSV_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RGBHSV_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// shared constants for the rgb to hsv pixel converter
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // default channel width
  localparam int PIXEL_BITS_DEF = 16;

  // full scale register width and reset value
  localparam int           CFG_W            = 16;
  localparam logic [15:0]  FULL_SCALE_RESET = 16'd255;

endpackage

>>> sv/rgbhsv_ifs.sv
// ----------------------------------------------------------------------------
// rgbhsv interfaces
// valid/ready channels for pixels in, hsv results out and configuration
// ----------------------------------------------------------------------------
interface rgbhsv_rgb_if #(
  parameter int W = rgbhsv_pkg::PIXEL_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] red_in;
  logic [W-1:0] green_in;
  logic [W-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rgbhsv_hsv_if #(
  parameter int W = rgbhsv_pkg::PIXEL_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] hue_out;
  logic [W-1:0] sat_out;
  logic [W-1:0] val_out;

  modport source (output valid, hue_out, sat_out, val_out, input ready);
  modport sink   (input valid, hue_out, sat_out, val_out, output ready);
endinterface

interface rgbhsv_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rgbhsv_pkg::CFG_W-1:0] full_scale;

  modport source (output valid, full_scale, input ready);
  modport sink   (input valid, full_scale, output ready);
endinterface

>>> sv/rgb_to_hsv_pixel.sv
// Throughput: one pixel per cycle while the skid buffer is empty; the two
// restoring dividers retire one quotient bit per pipeline stage, PIXEL_BITS
// stages deep.
// Reset: synchronous active-high rst clears all valid bits and the skid
// buffer and sets full_scale to 255.
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// pipelined rgb to hsv conversion with exact floored hue and saturation
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel #(
  parameter int PIXEL_BITS = rgbhsv_pkg::PIXEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  rgbhsv_cfg_if.sink         cfg,
  rgbhsv_rgb_if.sink         pix_in,
  rgbhsv_hsv_if.source       pix_out
);

  localparam int P = PIXEL_BITS;
  localparam int C = P + 3;

  // configuration register
  logic [rgbhsv_pkg::CFG_W-1:0] full_scale;
  logic [P-1:0]                 fs_p;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= rgbhsv_pkg::FULL_SCALE_RESET;
    end else if (cfg.valid) begin
      full_scale <= cfg.full_scale;
    end
  end
  assign fs_p = P'(full_scale);

  // global advance: pipeline moves whenever the skid buffer is empty
  logic skid_v;
  logic en;
  assign en           = !skid_v;
  assign pix_in.ready = en;

  // stage 1: clamp
  logic         v1;
  logic [P-1:0] r1, g1, b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pix_in.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r1 <= (pix_in.red_in   > fs_p) ? fs_p : pix_in.red_in;
      g1 <= (pix_in.green_in > fs_p) ? fs_p : pix_in.green_in;
      b1 <= (pix_in.blue_in  > fs_p) ? fs_p : pix_in.blue_in;
    end
  end

  // stage 2: max, min, delta and sector
  logic         mx_g, mn_g;
  logic [P-1:0] max_c, min_c, max_rg, min_rg;
  logic         v2, selr2, selg2;
  logic [P-1:0] r2, g2, b2, val2, d2;
  always_comb begin
    mx_g   = g1 > r1;
    mn_g   = g1 < r1;
    max_rg = mx_g ? g1 : r1;
    min_rg = mn_g ? g1 : r1;
    max_c  = (b1 > max_rg) ? b1 : max_rg;
    min_c  = (b1 < min_rg) ? b1 : min_rg;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r2    <= r1;
      g2    <= g1;
      b2    <= b1;
      val2  <= max_c;
      d2    <= max_c - min_c;
      selr2 <= (r1 == max_c);
      selg2 <= (g1 == max_c);
    end
  end

  // stage 3: hue numerator with wrap, divisors
  logic signed [C:0] rs, gs, bs, ds, n_raw, n_wr;
  logic              v3;
  logic [C-1:0]      n3, hc3, sc3;
  logic [P-1:0]      d3, val3;
  always_comb begin
    rs    = $signed({{(C+1-P){1'b0}}, r2});
    gs    = $signed({{(C+1-P){1'b0}}, g2});
    bs    = $signed({{(C+1-P){1'b0}}, b2});
    ds    = $signed({{(C+1-P){1'b0}}, d2});
    if (selr2) begin
      n_raw = gs - bs;
    end else if (selg2) begin
      n_raw = (ds <<< 1) + bs - rs;
    end else begin
      n_raw = (ds <<< 2) + rs - gs;
    end
    n_wr = (n_raw < 0) ? n_raw + (ds <<< 2) + (ds <<< 1) : n_raw;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      n3   <= C'(n_wr);
      hc3  <= (d2 == '0) ? C'(1) : C'(({{(C-P){1'b0}}, d2} << 2) + ({{(C-P){1'b0}}, d2} << 1));
      sc3  <= (val2 == '0) ? C'(1) : {{(C-P){1'b0}}, val2};
      d3   <= d2;
      val3 <= val2;
    end
  end

  // stage 4: products, split into first partial remainder and low bits
  logic [C+P-1:0] prod_h, prod_s;
  assign prod_h = {{P{1'b0}}, n3} * {{C{1'b0}}, fs_p};
  assign prod_s = {{C{1'b0}}, d3} * {{C{1'b0}}, fs_p};

  logic         dv [0:P];
  logic [C-1:0] hr [0:P];
  logic [C-1:0] sr [0:P];
  logic [P-1:0] hl [0:P];
  logic [P-1:0] sl [0:P];
  logic [C-1:0] hc [0:P];
  logic [C-1:0] sc [0:P];
  logic [P-1:0] vv [0:P];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      hr[0] <= prod_h[C+P-1:P];
      hl[0] <= prod_h[P-1:0];
      sr[0] <= prod_s[C+P-1:P];
      sl[0] <= prod_s[P-1:0];
      hc[0] <= hc3;
      sc[0] <= sc3;
      vv[0] <= val3;
    end
  end

  // restoring divider stages, one quotient bit each for hue and saturation
  for (genvar k = 0; k < P; k++) begin : g_div
    logic [C:0] th, ts;
    logic       qh, qs;
    always_comb begin
      th = {hr[k], hl[k][P-1]};
      ts = {sr[k], sl[k][P-1]};
      qh = th >= {1'b0, hc[k]};
      qs = ts >= {1'b0, sc[k]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        hr[k+1] <= qh ? C'(th - {1'b0, hc[k]}) : C'(th);
        sr[k+1] <= qs ? C'(ts - {1'b0, sc[k]}) : C'(ts);
        hl[k+1] <= {hl[k][P-2:0], qh};
        sl[k+1] <= {sl[k][P-2:0], qs};
        hc[k+1] <= hc[k];
        sc[k+1] <= sc[k];
        vv[k+1] <= vv[k];
      end
    end
  end

  // output register with skid buffer
  logic         out_v;
  logic [P-1:0] out_h, out_s, out_val;
  logic [P-1:0] skid_h, skid_s, skid_val;
  logic         take_new;

  assign take_new = en && dv[P];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pix_out.ready) begin
        skid_v <= 1'b0;
      end
    end else if (take_new) begin
      if (out_v && !pix_out.ready) begin
        skid_v <= 1'b1;
      end else begin
        out_v <= 1'b1;
      end
    end else if (pix_out.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (pix_out.ready) begin
        out_h   <= skid_h;
        out_s   <= skid_s;
        out_val <= skid_val;
      end
    end else if (take_new) begin
      if (out_v && !pix_out.ready) begin
        skid_h   <= hl[P];
        skid_s   <= sl[P];
        skid_val <= vv[P];
      end else begin
        out_h   <= hl[P];
        out_s   <= sl[P];
        out_val <= vv[P];
      end
    end
  end

  assign pix_out.valid   = out_v;
  assign pix_out.hue_out = out_h;
  assign pix_out.sat_out = out_s;
  assign pix_out.val_out = out_val;

  // checks
`include "rgb_to_hsv_pixel_assert.svh"

  `RGBHSV_ASSERT_IMPLIES(a_skid_needs_out, clk, rst, skid_v, out_v,
                         "skid full with empty output")
  `RGBHSV_ASSERT_IMPLIES(a_black_zero, clk, rst, out_v && out_val == '0,
                         out_h == '0 && out_s == '0,
                         "black pixel with nonzero hue or saturation")
  `RGBHSV_ASSERT_ALWAYS(a_no_accept_when_skid, clk, rst, !(skid_v && pix_in.ready),
                        "input accepted while skid full")

endmodule
